### sv/sbl_pkg.sv
// Package for the sorted byte list: capacity, widths, command and status codes,
// the control state type and the word broadcast along the chain of cells.
// Has no dependencies; every other file in sv/ uses it.
package sbl_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned ValueW   = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned EntryCntW = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DELETED   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ins_en;
    logic              del_en;
  } cell_ctl_t;

endpackage

### sv/sbl_if.sv
// Valid/ready channel interfaces for the command and result transfers.
// Depends on sbl_pkg for the payload widths.
interface sbl_cmd_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [sbl_pkg::ValueW-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface sbl_res_if;
  logic                         valid;
  logic                         ready;
  logic [sbl_pkg::StatusW-1:0]  status;
  logic [sbl_pkg::EntryCntW-1:0] entry_count;
  logic [sbl_pkg::ValueW-1:0]   smallest;

  modport source (output valid, status, entry_count, smallest, input ready);
  modport sink   (input valid, status, entry_count, smallest, output ready);
endinterface

### sv/sorted_byte_list_insert_delete.sv
// Top level of the sorted byte list: command/result handshakes, entry count,
// status decode and the chain of sbl_cell instances.
// Depends on sbl_pkg, sbl_if (sbl_cmd_if, sbl_res_if) and sbl_cell.
//
//   Channel   Direction  Payload                          Transfer when
//   cmd_i     in         command, value                   cmd_i.valid && cmd_i.ready
//   res_o     out        status, entry_count, smallest    res_o.valid && res_o.ready
//
// The transfer cycle registers each command; in its execute cycle every cell
// compares its entry with the value and shifts in one step while the result is
// written into the output register.
// A new command is taken once the block is back in idle; a result still held
// back by the sink then stalls the execute cycle of that following command.
// Reset clears the control state and the entry count; entries are not cleared.
module sorted_byte_list_insert_delete (
  input  logic clk_i,
  input  logic rst_ni,
  sbl_cmd_if.sink   cmd_i,
  sbl_res_if.source res_o
);
  import sbl_pkg::*;

  state_e state_q, state_d;

  // The command held for its execute cycle.
  logic              cmd_q;
  logic [ValueW-1:0] value_q;

  logic [CountW-1:0] count_q, count_d;

  // Result register, which parts the cells from the sink.
  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic [EntryCntW-1:0] out_count_q;
  logic [ValueW-1:0]    smallest_q, smallest_d;

  logic      go, is_insert, is_full, is_empty, found;
  cell_ctl_t ctl;

  logic [Capacity-1:0]             lt_vec, eq_vec, occ_vec;
  logic [Capacity-1:0][ValueW-1:0] entry_vec, entry_d_vec;

  // The execute cycle goes ahead only when the result register is free
  // or is being emptied in the same cycle.
  assign go        = (state_q == ST_EXEC) && (!out_valid_q || res_o.ready);
  assign is_insert = (cmd_q == CMD_INSERT);
  assign is_full   = (count_q == CountW'(Capacity));
  assign is_empty  = (count_q == '0);
  assign found     = |eq_vec;

  assign ctl.value  = value_q;
  assign ctl.ins_en = go && is_insert && !is_full;
  assign ctl.del_en = go && !is_insert && found;

  // The chain. Cell 0 sees a virtual left neighbour that is below every
  // value, so an insert lands there when no entry is smaller. The last cell
  // takes its own entry on a delete; that entry then lies above the count.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic              left_lt;
    logic [ValueW-1:0] left_entry, right_entry;

    assign occ_vec[i] = (CountW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = value_q;
    end else begin : g_mid
      assign left_lt    = lt_vec[i-1];
      assign left_entry = entry_vec[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_entry = entry_vec[i];
    end else begin : g_inner
      assign right_entry = entry_vec[i+1];
    end

    sbl_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occ_i         (occ_vec[i]),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entry_vec[i]),
      .entry_d_o     (entry_d_vec[i]),
      .lt_o          (lt_vec[i]),
      .eq_o          (eq_vec[i])
    );
  end

  // Next state, count, status and result register.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = STAT_NOT_FOUND;
    out_valid_d = out_valid_q && !res_o.ready;

    if (is_insert) begin
      status_d = is_full ? STAT_FULL : STAT_INSERTED;
    end else if (is_empty) begin
      status_d = STAT_EMPTY;
    end else if (found) begin
      status_d = STAT_DELETED;
    end

    if (ctl.ins_en) begin
      count_d = count_q + 1'b1;
    end else if (ctl.del_en) begin
      count_d = count_q - 1'b1;
    end

    // The head is read from what cell 0 is about to hold.
    smallest_d = (count_d != '0) ? entry_d_vec[0] : '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cmd_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q   <= cmd_i.command;
      value_q <= cmd_i.value;
    end
    if (go) begin
      status_q    <= status_d;
      out_count_q <= EntryCntW'(count_d);
      smallest_q  <= smallest_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = status_q;
  assign res_o.entry_count = out_count_q;
  assign res_o.smallest    = smallest_q;

`ifndef SYNTHESIS
  // The count never goes beyond the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Capacity))
    else $error("entry count above capacity");

  // The count moves by at most one per command.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + 1'b1) ||
                          (count_q + 1'b1 == $past(count_q)))
    else $error("entry count moved by more than one");

  // The stored entries stay sorted: the cells below the value form a prefix.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lt_vec & (lt_vec + 1'b1)) == '0)
    else $error("entries out of order");

  // A new result appears only at the end of an execute cycle.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EXEC)
    else $error("result without a command");

  // A refused or failed command leaves the count alone.
  a_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (status_d == STAT_FULL || status_d == STAT_EMPTY ||
           status_d == STAT_NOT_FOUND) |=> $stable(count_q))
    else $error("count changed by a refused command");
`endif

endmodule

### sv/sbl_cell.sv
// One cell of the sorted chain: holds one entry, compares it with the broadcast
// value and takes its own, the new or a neighbour's entry. Depends on sbl_pkg.
module sbl_cell (
  input  logic                       clk_i,
  input  sbl_pkg::cell_ctl_t         ctl_i,
  input  logic                       occ_i,
  input  logic                       left_lt_i,
  input  logic [sbl_pkg::ValueW-1:0] left_entry_i,
  input  logic [sbl_pkg::ValueW-1:0] right_entry_i,
  output logic [sbl_pkg::ValueW-1:0] entry_o,
  output logic [sbl_pkg::ValueW-1:0] entry_d_o,
  output logic                       lt_o,
  output logic                       eq_o
);
  import sbl_pkg::*;

  logic [ValueW-1:0] entry_q, entry_d;

  // An occupied entry below the value stays where it is for both commands.
  assign lt_o = occ_i && (entry_q < ctl_i.value);
  assign eq_o = occ_i && (entry_q == ctl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins_en && !lt_o) begin
      entry_d = left_lt_i ? ctl_i.value : left_entry_i;
    end else if (ctl_i.del_en && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

### test/tb_sorted_byte_list_insert_delete.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_byte_list_insert_delete: drives commands,
// mirrors the sorted list and checks every result, field by field, in order.
// Depends on sbl_pkg, the sbl_cmd_if and sbl_res_if interfaces and the block.
module tb_sorted_byte_list_insert_delete;
  import sbl_pkg::*;

  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned ItemsPerPhase = 430;

  typedef enum int {
    PH_NONE,
    PH_SENDER,
    PH_RECEIVER,
    PH_BOTH
  } idle_phase_e;

  // Where the values of a burst of random commands are drawn from.
  typedef enum int {
    SPREAD_FULL,
    SPREAD_LOW,
    SPREAD_HIGH
  } value_spread_e;

  typedef struct {
    status_e                status;
    logic [EntryCntW-1:0]   entry_count;
    logic [ValueW-1:0]      smallest;
  } list_report_t;

  // Shadow copy of the sorted list, together with the queue of reports that
  // the block owes for commands it has already taken.
  class list_shadow;
    logic [ValueW-1:0] entries [Capacity];
    int unsigned       fill;
    list_report_t      awaited [$];
    int unsigned       errors;
    int unsigned       reports;
    int unsigned       status_seen [5];

    function void apply_command(cmd_e c, logic [ValueW-1:0] v);
      list_report_t r;
      int unsigned  pos;
      int unsigned  i;
      pos = 0;
      if (c == CMD_INSERT) begin
        if (fill >= Capacity) begin
          r.status = STAT_FULL;
        end else begin
          // The new entry goes in front of equal ones.
          while (pos < fill && v > entries[pos]) pos++;
          for (i = fill; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = v;
          fill++;
          r.status = STAT_INSERTED;
        end
      end else if (fill == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        while (pos < fill && entries[pos] != v) pos++;
        if (pos >= fill) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
          fill--;
          r.status = STAT_DELETED;
        end
      end
      r.entry_count = EntryCntW'(fill);
      r.smallest    = (fill > 0) ? entries[0] : '0;
      awaited.push_back(r);
    endfunction

    function void check_report(logic [StatusW-1:0] st, logic [EntryCntW-1:0] cnt,
                               logic [ValueW-1:0] sm);
      list_report_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: status %0d count %0d smallest %0d",
                 $time, st, cnt, sm);
        return;
      end
      exp = awaited.pop_front();
      reports++;
      status_seen[int'(exp.status)]++;
      if (st !== exp.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d (%s), actual %0d",
                 $time, exp.status, exp.status.name(), st);
      end
      if (cnt !== exp.entry_count) begin
        errors++;
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, exp.entry_count, cnt);
      end
      if (sm !== exp.smallest) begin
        errors++;
        $display("%0t: smallest mismatch: expected %0d, actual %0d",
                 $time, exp.smallest, sm);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  idle_phase_e phase;
  int unsigned idle_cycles;
  int unsigned commands_sent;
  list_shadow  shadow = new;

  sbl_cmd_if cmd_if ();
  sbl_res_if res_if ();

  sorted_byte_list_insert_delete DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The result side stalls according to the current idling phase.
  always @(posedge clk) begin
    res_if.ready <= !((phase == PH_RECEIVER && $urandom_range(99) < 85) ||
                      (phase == PH_BOTH && $urandom_range(99) < 10));
  end

  // Every result transfer is checked against the oldest outstanding report.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      shadow.check_report(res_if.status, res_if.entry_count, res_if.smallest);
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, shadow.awaited.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one command, with gaps before it as the phase asks, and notes it
  // in the shadow list once the transfer has taken place.
  task automatic send_command(input cmd_e c, input logic [ValueW-1:0] v);
    while ((phase == PH_SENDER && $urandom_range(99) < 85) ||
           (phase == PH_BOTH && $urandom_range(99) < 10)) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= c;
    cmd_if.value   <= v;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    shadow.apply_command(c, v);
    commands_sent++;
  endtask

  // Random commands in bursts: each burst leans towards filling, towards draining
  // or to neither and draws its values from one range, so the list runs full and
  // empty often and duplicates are common. Most deletes aim at stored values.
  task automatic run_random(input int unsigned n_items);
    int unsigned   left;
    int unsigned   insert_pct;
    int unsigned   k;
    value_spread_e spread;
    cmd_e          c;
    logic [ValueW-1:0] v;
    left       = 0;
    insert_pct = 50;
    spread     = SPREAD_FULL;
    for (k = 0; k < n_items; k++) begin
      if (left == 0) begin
        left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 20;
        endcase
        spread = value_spread_e'($urandom_range(2));
      end
      left--;
      if ($urandom_range(99) < 10) begin
        c = cmd_e'($urandom_range(1));
        v = ValueW'($urandom);
      end else begin
        c = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
        if (c == CMD_DELETE && shadow.fill > 0 && $urandom_range(99) < 75) begin
          v = shadow.entries[$urandom_range(shadow.fill - 1)];
        end else begin
          case (spread)
            SPREAD_LOW:  v = ValueW'($urandom_range(7));
            SPREAD_HIGH: v = ValueW'($urandom_range(255, 248));
            default:     v = ValueW'($urandom);
          endcase
        end
      end
      send_command(c, v);
    end
  endtask

  initial begin
    int unsigned k;
    phase          = PH_NONE;
    idle_cycles    = 0;
    commands_sent  = 0;
    rst_n          = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_INSERT;
    cmd_if.value   = '0;
    res_if.ready   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: delete from an empty list, the value extremes, a
    // duplicate pair, an absent value, deleting zero, filling the list to
    // capacity and a refused insert into the full list.
    send_command(CMD_DELETE, 8'd5);
    send_command(CMD_INSERT, 8'd255);
    send_command(CMD_INSERT, 8'd0);
    send_command(CMD_INSERT, 8'd128);
    send_command(CMD_INSERT, 8'd128);
    send_command(CMD_DELETE, 8'd77);
    send_command(CMD_DELETE, 8'd0);
    send_command(CMD_DELETE, 8'd128);
    for (k = 0; k < Capacity - 2; k++) send_command(CMD_INSERT, ValueW'(k * 17 + 3));
    send_command(CMD_INSERT, 8'd42);
    send_command(CMD_DELETE, 8'd255);
    send_command(CMD_DELETE, 8'd255);

    // Random part, once in each idling phase.
    phase = PH_NONE;
    run_random(ItemsPerPhase);
    phase = PH_SENDER;
    run_random(ItemsPerPhase);
    phase = PH_RECEIVER;
    run_random(ItemsPerPhase);
    phase = PH_BOTH;
    run_random(ItemsPerPhase);
    cmd_if.valid <= 1'b0;

    // Drain the outstanding results, then allow for the block's latency.
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d commands across four idling phases; %0d results checked, %0d errors.",
             commands_sent, shadow.reports, shadow.errors);
    $display("Results by status: inserted %0d, deleted %0d, not found %0d, empty %0d, full %0d.",
             shadow.status_seen[STAT_INSERTED], shadow.status_seen[STAT_DELETED],
             shadow.status_seen[STAT_NOT_FOUND], shadow.status_seen[STAT_EMPTY],
             shadow.status_seen[STAT_FULL]);
    if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sorted_byte_list_insert_delete.f
sv/sbl_pkg.sv
sv/sbl_if.sv
sv/sbl_cell.sv
sv/sorted_byte_list_insert_delete.sv
test/tb_sorted_byte_list_insert_delete.sv
